@@ hdl/olr_pkg.sv @@
// ----------------------------------------------------------------------------
// olr_pkg
// Shared types and constants for the octant line rasterizer: coordinate and
// address widths, octant bit positions, item kinds and the stage payloads.
// ----------------------------------------------------------------------------
package olr_pkg;

   // Coordinate width; all coordinate arithmetic wraps at this width.
   localparam int COORD_BITS = 12;

   // Row pitch register and framebuffer word address widths.
   localparam int PITCH_BITS = 13;
   localparam int ADDR_BITS = 24;

   // Product width wide enough for y times pitch and for the address.
   localparam int PROD_BITS = (COORD_BITS + PITCH_BITS > ADDR_BITS) ?
                              (COORD_BITS + PITCH_BITS) : ADDR_BITS;

   // Error sum and doubled delta widths.
   localparam int TWICE_BITS = COORD_BITS + 1;
   localparam int ERR_BITS = COORD_BITS + 3;

   // Row pitch after reset.
   localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(640);

   // Item kinds.
   localparam logic KIND_BEGIN = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   // Octant bit positions.
   localparam int OCT_SWAP = 0;
   localparam int OCT_XNEG = 1;
   localparam int OCT_YNEG = 2;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);

   // A classified item as it travels through the queue.
   typedef struct packed {
      logic                  begin_line;
      logic [2:0]            octant;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
      logic [COORD_BITS-1:0] major_len;
      logic [COORD_BITS-1:0] minor_len;
   } command_type;

   // A pixel on its way to the address stage.
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
   } pixel_type;

endpackage

@@ hdl/olr_front.sv @@
// ----------------------------------------------------------------------------
// olr_front
// Classifies an incoming item. A begin item has its delta folded into the
// first octant: absolute deltas, octant bits and major/minor lengths.
// ----------------------------------------------------------------------------
module olr_front (
   input  logic                           req_kind,
   input  logic [olr_pkg::COORD_BITS-1:0] req_x_start,
   input  logic [olr_pkg::COORD_BITS-1:0] req_y_start,
   input  logic [olr_pkg::COORD_BITS-1:0] req_x_end,
   input  logic [olr_pkg::COORD_BITS-1:0] req_y_end,
   output olr_pkg::command_type           cmd
);
   import olr_pkg::*;

   logic                  x_neg;
   logic                  y_neg;
   logic                  swap;
   logic [COORD_BITS-1:0] abs_dx;
   logic [COORD_BITS-1:0] abs_dy;

   // Absolute deltas and their directions.
   always_comb begin
      x_neg = (req_x_end < req_x_start);
      y_neg = (req_y_end < req_y_start);
      abs_dx = x_neg ? (req_x_start - req_x_end) : (req_x_end - req_x_start);
      abs_dy = y_neg ? (req_y_start - req_y_end) : (req_y_end - req_y_start);
      swap = (abs_dx < abs_dy);
   end

   // Build the command; the longer delta becomes the major axis.
   always_comb begin
      cmd.begin_line = (req_kind == KIND_BEGIN);
      cmd.octant[OCT_SWAP] = swap;
      cmd.octant[OCT_XNEG] = x_neg;
      cmd.octant[OCT_YNEG] = y_neg;
      cmd.origin_x = req_x_start;
      cmd.origin_y = req_y_start;
      cmd.major_len = swap ? abs_dy : abs_dx;
      cmd.minor_len = swap ? abs_dx : abs_dy;
   end

endmodule

@@ hdl/olr_queue.sv @@
// ----------------------------------------------------------------------------
// olr_queue
// Short command queue that decouples the classifying front from the
// stepping back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module olr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  olr_pkg::command_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 cmd_valid,
   output olr_pkg::command_type cmd
);
   import olr_pkg::*;

   command_type               storage_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_IDX_BITS-1:0] wr_ptr_in;
   logic [QUEUE_IDX_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_IDX_BITS-1:0] rd_ptr_in;
   logic [QUEUE_IDX_BITS:0]   count_ff;
   logic [QUEUE_IDX_BITS:0]   count_in;

   // Status toward both sides.
   assign full = (count_ff == (QUEUE_IDX_BITS+1)'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd = storage_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/olr_back.sv @@
// ----------------------------------------------------------------------------
// olr_back
// Line stepping engine. Holds the state of the line in progress, emits one
// pixel per command on a live line and steps the minor axis by the error term.
// ----------------------------------------------------------------------------
module olr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  olr_pkg::command_type cmd,
   output logic                 cmd_pop,
   output logic                 pix_valid,
   output olr_pkg::pixel_type   pix,
   input  logic                 pix_take
);
   import olr_pkg::*;

   logic                       active_ff;
   logic                       active_in;
   logic [2:0]                 octant_ff;
   logic [2:0]                 octant_in;
   logic [COORD_BITS-1:0]      origin_x_ff;
   logic [COORD_BITS-1:0]      origin_x_in;
   logic [COORD_BITS-1:0]      origin_y_ff;
   logic [COORD_BITS-1:0]      origin_y_in;
   logic [COORD_BITS-1:0]      major_pos_ff;
   logic [COORD_BITS-1:0]      major_pos_in;
   logic [COORD_BITS-1:0]      minor_pos_ff;
   logic [COORD_BITS-1:0]      minor_pos_in;
   logic [COORD_BITS-1:0]      major_len_ff;
   logic [COORD_BITS-1:0]      major_len_in;
   logic signed [ERR_BITS-1:0] error_sum_ff;
   logic signed [ERR_BITS-1:0] error_sum_in;
   logic [TWICE_BITS-1:0]      twice_major_ff;
   logic [TWICE_BITS-1:0]      twice_major_in;
   logic [TWICE_BITS-1:0]      twice_minor_ff;
   logic [TWICE_BITS-1:0]      twice_minor_in;
   logic                       pix_valid_ff;
   logic                       pix_valid_in;
   pixel_type                  pix_ff;
   pixel_type                  pix_in;

   logic                       pix_ready;
   logic                       live;
   logic                       emit;
   logic [2:0]                 cur_octant;
   logic [COORD_BITS-1:0]      cur_origin_x;
   logic [COORD_BITS-1:0]      cur_origin_y;
   logic [COORD_BITS-1:0]      cur_major_pos;
   logic [COORD_BITS-1:0]      cur_minor_pos;
   logic [COORD_BITS-1:0]      cur_major_len;
   logic signed [ERR_BITS-1:0] cur_error;
   logic [TWICE_BITS-1:0]      cur_twice_major;
   logic [TWICE_BITS-1:0]      cur_twice_minor;
   logic [COORD_BITS-1:0]      x_off;
   logic [COORD_BITS-1:0]      y_off;
   logic                       is_last;
   logic signed [ERR_BITS-1:0] error_step;

   // The pixel register takes a new pixel when empty or being drained.
   assign pix_ready = !pix_valid_ff || pix_take;
   assign cmd_pop = cmd_valid && pix_ready;
   assign pix_valid = pix_valid_ff;
   assign pix = pix_ff;

   // Working line state: a begin command starts fresh, an advance uses
   // the stored state.
   always_comb begin
      if (cmd.begin_line) begin
         live = 1'b1;
         cur_octant = cmd.octant;
         cur_origin_x = cmd.origin_x;
         cur_origin_y = cmd.origin_y;
         cur_major_pos = '0;
         cur_minor_pos = '0;
         cur_major_len = cmd.major_len;
         cur_error = ERR_BITS'($signed({1'b0, cmd.major_len}));
         cur_twice_major = {cmd.major_len, 1'b0};
         cur_twice_minor = {cmd.minor_len, 1'b0};
      end else begin
         live = active_ff;
         cur_octant = octant_ff;
         cur_origin_x = origin_x_ff;
         cur_origin_y = origin_y_ff;
         cur_major_pos = major_pos_ff;
         cur_minor_pos = minor_pos_ff;
         cur_major_len = major_len_ff;
         cur_error = error_sum_ff;
         cur_twice_major = twice_major_ff;
         cur_twice_minor = twice_minor_ff;
      end
      emit = cmd_pop && live;
   end

   // Unfold the current position back into screen coordinates.
   always_comb begin
      x_off = cur_octant[OCT_SWAP] ? cur_minor_pos : cur_major_pos;
      y_off = cur_octant[OCT_SWAP] ? cur_major_pos : cur_minor_pos;
      pix_in.x = cur_octant[OCT_XNEG] ? (cur_origin_x - x_off) : (cur_origin_x + x_off);
      pix_in.y = cur_octant[OCT_YNEG] ? (cur_origin_y - y_off) : (cur_origin_y + y_off);
      is_last = (cur_major_pos >= cur_major_len);
      pix_in.last = is_last;
      pix_valid_in = pix_ready ? emit : pix_valid_ff;
   end

   // One Bresenham step: lose twice the minor length, and on underflow
   // take a minor step and add twice the major length back.
   always_comb begin
      active_in = active_ff;
      octant_in = octant_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      major_pos_in = major_pos_ff;
      minor_pos_in = minor_pos_ff;
      major_len_in = major_len_ff;
      error_sum_in = error_sum_ff;
      twice_major_in = twice_major_ff;
      twice_minor_in = twice_minor_ff;
      error_step = cur_error - ERR_BITS'($signed({2'b00, cur_twice_minor}));
      if (emit) begin
         octant_in = cur_octant;
         origin_x_in = cur_origin_x;
         origin_y_in = cur_origin_y;
         major_len_in = cur_major_len;
         twice_major_in = cur_twice_major;
         twice_minor_in = cur_twice_minor;
         minor_pos_in = cur_minor_pos;
         error_sum_in = cur_error;
         if (is_last) begin
            active_in = 1'b0;
            major_pos_in = cur_major_pos;
         end else begin
            active_in = 1'b1;
            major_pos_in = cur_major_pos + 1'b1;
            if (error_step < 0) begin
               minor_pos_in = cur_minor_pos + 1'b1;
               error_sum_in = error_step + ERR_BITS'($signed({2'b00, cur_twice_major}));
            end else begin
               error_sum_in = error_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         octant_ff <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         major_pos_ff <= '0;
         minor_pos_ff <= '0;
         major_len_ff <= '0;
         error_sum_ff <= '0;
         twice_major_ff <= '0;
         twice_minor_ff <= '0;
         pix_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         octant_ff <= octant_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         major_pos_ff <= major_pos_in;
         minor_pos_ff <= minor_pos_in;
         major_len_ff <= major_len_in;
         error_sum_ff <= error_sum_in;
         twice_major_ff <= twice_major_in;
         twice_minor_ff <= twice_minor_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   // Pixel payload needs no reset.
   always_ff @(posedge clock) begin
      if (pix_ready) begin
         pix_ff <= pix_in;
      end
   end

endmodule

@@ hdl/olr_addr.sv @@
// ----------------------------------------------------------------------------
// olr_addr
// Address stage and output register. Holds the row pitch register and
// forms the framebuffer word address x plus y times pitch.
// ----------------------------------------------------------------------------
module olr_addr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [olr_pkg::PITCH_BITS-1:0] csr_wr_data,
   input  logic                           pix_valid,
   input  olr_pkg::pixel_type             pix,
   output logic                           pix_take,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [olr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic [olr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic [olr_pkg::ADDR_BITS-1:0]  rsp_pixel_addr,
   output logic                           rsp_last_pixel
);
   import olr_pkg::*;

   logic [PITCH_BITS-1:0] pitch_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff;
   logic [COORD_BITS-1:0] rsp_y_ff;
   logic [ADDR_BITS-1:0]  rsp_addr_ff;
   logic [ADDR_BITS-1:0]  rsp_addr_in;
   logic                  rsp_last_ff;
   logic                  out_ready;
   logic [PROD_BITS-1:0]  row_base;
   logic [PROD_BITS-1:0]  addr_sum;

   // Row pitch register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PITCH_RESET;
      end else if (csr_wr_en) begin
         pitch_ff <= csr_wr_data;
      end
   end

   // The output register refills when empty or when its item is taken.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign pix_take = pix_valid && out_ready;
   assign rsp_valid_in = out_ready ? pix_valid : rsp_valid_ff;

   // Word address, wrapped to the address width.
   always_comb begin
      row_base = PROD_BITS'(pix.y) * PROD_BITS'(pitch_ff);
      addr_sum = row_base + PROD_BITS'(pix.x);
      rsp_addr_in = addr_sum[ADDR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_x_ff <= pix.x;
         rsp_y_ff <= pix.y;
         rsp_addr_ff <= rsp_addr_in;
         rsp_last_ff <= pix.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_x = rsp_x_ff;
   assign rsp_pixel_y = rsp_y_ff;
   assign rsp_pixel_addr = rsp_addr_ff;
   assign rsp_last_pixel = rsp_last_ff;

endmodule

@@ hdl/octant_line_rasterizer.sv @@
// A result passes through the command queue, the pixel register and the output register.
// Throughput: one item per cycle while the queue has room; a result-side stall can fill the queue.
// A four-entry command queue lets the front keep accepting while the result side stalls.
// Reset clears the line state, empties the queue and the output, and sets row pitch to 640.
// ----------------------------------------------------------------------------
// octant_line_rasterizer
// Octant-folding Bresenham line rasterizer: begin items start a line and
// emit its first pixel, advance items emit the following pixels.
// ----------------------------------------------------------------------------
module octant_line_rasterizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [olr_pkg::PITCH_BITS-1:0] csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [olr_pkg::COORD_BITS-1:0] req_x_start,
   input  logic [olr_pkg::COORD_BITS-1:0] req_y_start,
   input  logic [olr_pkg::COORD_BITS-1:0] req_x_end,
   input  logic [olr_pkg::COORD_BITS-1:0] req_y_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [olr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic [olr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic [olr_pkg::ADDR_BITS-1:0]  rsp_pixel_addr,
   output logic                           rsp_last_pixel
);
   import olr_pkg::*;

   command_type front_cmd;
   command_type queue_cmd;
   logic        queue_full;
   logic        queue_push;
   logic        queue_valid;
   logic        queue_pop;
   logic        pix_valid;
   pixel_type   pix;
   logic        pix_take;

   // An item is accepted whenever the queue has room.
   assign req_stall = queue_full;
   assign queue_push = req_valid && !queue_full;

   olr_front u_front (
      .req_kind    (req_kind),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .cmd         (front_cmd)
   );

   olr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_cmd  (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd)
   );

   olr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_take  (pix_take)
   );

   olr_addr u_addr (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .pix_valid      (pix_valid),
      .pix            (pix),
      .pix_take       (pix_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_addr (rsp_pixel_addr),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

@@ dv/olr_checker.sv @@
// ----------------------------------------------------------------------------
// olr_checker
// Watches the request, result and register ports of the line rasterizer,
// predicts every pixel from the accepted items and compares each accepted
// result, field by field, against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module olr_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [olr_pkg::PITCH_BITS-1:0] csr_wr_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_kind,
   input  logic [olr_pkg::COORD_BITS-1:0] req_x_start,
   input  logic [olr_pkg::COORD_BITS-1:0] req_y_start,
   input  logic [olr_pkg::COORD_BITS-1:0] req_x_end,
   input  logic [olr_pkg::COORD_BITS-1:0] req_y_end,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [olr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   input  logic [olr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   input  logic [olr_pkg::ADDR_BITS-1:0]  rsp_pixel_addr,
   input  logic                           rsp_last_pixel,
   output int                             error_count,
   output int                             open_count
);
   import olr_pkg::*;

   // One predicted pixel as it should leave the block.
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [ADDR_BITS-1:0]  addr;
      logic                  last;
   } pixel_expect_type;

   // Shadow of the row pitch register and of the line walker.
   logic [PITCH_BITS-1:0] pitch;
   logic                  line_active;
   logic [2:0]            line_octant;
   logic [COORD_BITS-1:0] org_x;
   logic [COORD_BITS-1:0] org_y;
   logic [COORD_BITS-1:0] steps_taken;
   logic [COORD_BITS-1:0] minor_steps;
   logic [COORD_BITS-1:0] line_len;
   int                    err_acc;
   int                    dbl_major;
   int                    dbl_minor;

   pixel_expect_type pending_pixels[$];
   pixel_expect_type want;

   // Print one line for a mismatch and count it.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   // Predict the current pixel, then advance the walker by one step.
   task automatic emit_pixel();
      logic [COORD_BITS-1:0] along;
      logic [COORD_BITS-1:0] across;
      logic [COORD_BITS-1:0] px;
      logic [COORD_BITS-1:0] py;
      logic [31:0]           wide_addr;
      pixel_expect_type      pix;
      along = steps_taken;
      across = minor_steps;
      if (line_octant[OCT_SWAP]) begin
         along = minor_steps;
         across = steps_taken;
      end
      px = line_octant[OCT_XNEG] ? (org_x - along) : (org_x + along);
      py = line_octant[OCT_YNEG] ? (org_y - across) : (org_y + across);
      wide_addr = 32'(px) + 32'(py) * 32'(pitch);
      pix.x = px;
      pix.y = py;
      pix.addr = wide_addr[ADDR_BITS-1:0];
      pix.last = (steps_taken >= line_len);
      pending_pixels.push_back(pix);
      if (pix.last) begin
         line_active = 1'b0;
      end else begin
         steps_taken++;
         err_acc -= dbl_minor;
         if (err_acc < 0) begin
            minor_steps++;
            err_acc += dbl_major;
         end
      end
   endtask

   // Fold the delta of a new line into the first octant and emit its first pixel.
   task automatic start_line(input logic [COORD_BITS-1:0] xs, input logic [COORD_BITS-1:0] ys,
                             input logic [COORD_BITS-1:0] xe, input logic [COORD_BITS-1:0] ye);
      int         adx;
      int         ady;
      int         hold;
      logic [2:0] oct;
      oct = 3'b000;
      if (ye < ys) begin
         ady = int'(ys) - int'(ye);
         oct[OCT_YNEG] = 1'b1;
      end else begin
         ady = int'(ye) - int'(ys);
      end
      if (xe < xs) begin
         adx = int'(xs) - int'(xe);
         oct[OCT_XNEG] = 1'b1;
      end else begin
         adx = int'(xe) - int'(xs);
      end
      if (adx < ady) begin
         hold = adx;
         adx = ady;
         ady = hold;
         oct[OCT_SWAP] = 1'b1;
      end
      line_octant = oct;
      org_x = xs;
      org_y = ys;
      steps_taken = '0;
      minor_steps = '0;
      line_len = COORD_BITS'(adx);
      err_acc = adx;
      dbl_major = 2 * adx;
      dbl_minor = 2 * ady;
      line_active = 1'b1;
      emit_pixel();
   endtask

   // Compare results first, then fold in register writes and new items.
   always @(posedge clock) begin
      if (reset) begin
         pitch = PITCH_RESET;
         line_active = 1'b0;
         line_octant = 3'b000;
         org_x = '0;
         org_y = '0;
         steps_taken = '0;
         minor_steps = '0;
         line_len = '0;
         err_acc = 0;
         dbl_major = 0;
         dbl_minor = 0;
         pending_pixels.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                         rsp_pixel_x, rsp_pixel_y));
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_x !== want.x) begin
                  report_mismatch($sformatf("pixel_x got %0d, expected %0d",
                                            rsp_pixel_x, want.x));
               end
               if (rsp_pixel_y !== want.y) begin
                  report_mismatch($sformatf("pixel_y got %0d, expected %0d",
                                            rsp_pixel_y, want.y));
               end
               if (rsp_pixel_addr !== want.addr) begin
                  report_mismatch($sformatf("pixel_addr got %0d, expected %0d",
                                            rsp_pixel_addr, want.addr));
               end
               if (rsp_last_pixel !== want.last) begin
                  report_mismatch($sformatf("last_pixel got %0b, expected %0b",
                                            rsp_last_pixel, want.last));
               end
            end
         end
         if (csr_wr_en) begin
            pitch = csr_wr_data;
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            if (req_kind == KIND_BEGIN) begin
               start_line(req_x_start, req_y_start, req_x_end, req_y_end);
            end else if (line_active) begin
               emit_pixel();
            end
         end
      end
      open_count <= pending_pixels.size();
   end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the octant line rasterizer: directed corner lines,
// then random line sequences under several row pitches, with bursty request
// traffic, result-side stalls and one long result hold.
// ----------------------------------------------------------------------------
module tb_top;
   import olr_pkg::*;

   localparam int COORD_MAX = (1 << COORD_BITS) - 1;
   localparam logic [COORD_BITS-1:0] COORD_TOP = COORD_BITS'(COORD_MAX);

   // Result-side stall patterns.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_RUNS
   } stall_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [PITCH_BITS-1:0] csr_wr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [COORD_BITS-1:0] req_x_start;
   logic [COORD_BITS-1:0] req_y_start;
   logic [COORD_BITS-1:0] req_x_end;
   logic [COORD_BITS-1:0] req_y_end;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [COORD_BITS-1:0] rsp_pixel_x;
   logic [COORD_BITS-1:0] rsp_pixel_y;
   logic [ADDR_BITS-1:0]  rsp_pixel_addr;
   logic                  rsp_last_pixel;

   int             error_count;
   int             open_count;
   stall_mode_type stall_mode;
   bit             hold_long;
   int             burst_left;
   int             gap_max;
   int             items_sent;
   int             lines_begun;
   int             pitch_settings;

   octant_line_rasterizer u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_addr (rsp_pixel_addr),
      .rsp_last_pixel (rsp_last_pixel)
   );

   olr_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_addr (rsp_pixel_addr),
      .rsp_last_pixel (rsp_last_pixel),
      .error_count    (error_count),
      .open_count     (open_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #5000000;
      $display("Timeout with %0d pixels still expected.", open_count);
      $display("octant_line_rasterizer test failed");
      $finish;
   end

   // Result receiver: stall pattern per phase, plus one long counted hold.
   initial begin
      int   run_left;
      int   hold_left;
      bit   hold_taken;
      logic run_state;
      run_left = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      run_state = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_long && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 300;
         end else if (!hold_long) begin
            hold_taken = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               STALL_HEAVY: begin
                  rsp_stall <= ($urandom_range(0, 1) == 0);
               end
               default: begin
                  if (run_left == 0) begin
                     run_state = ~run_state;
                     run_left = run_state ? $urandom_range(1, 12) : $urandom_range(1, 6);
                  end
                  run_left--;
                  rsp_stall <= run_state;
               end
            endcase
         end
      end
   end

   // Offer one item and hold it until accepted; bursts end with a random gap.
   task automatic send_item(input logic kind,
                            input logic [COORD_BITS-1:0] xs, input logic [COORD_BITS-1:0] ys,
                            input logic [COORD_BITS-1:0] xe, input logic [COORD_BITS-1:0] ye);
      int gap;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end <= xe;
      req_y_end <= ye;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (kind == KIND_BEGIN) begin
         lines_begun++;
      end
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Advance item with random, ignored coordinate fields.
   task automatic send_advance();
      send_item(KIND_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                COORD_BITS'($urandom), COORD_BITS'($urandom));
   endtask

   // Stop offering and wait for every predicted pixel plus a quiet tail.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (8) @(posedge clock);
   endtask

   // Write the row pitch register while the block is idle.
   task automatic write_pitch(input int value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= PITCH_BITS'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pitch_settings++;
   endtask

   // Random lines: mostly complete lines, some cut short by a new begin,
   // some overrun past the end, and a few stray advance items.
   task automatic run_random(input int target);
      int                    made;
      int                    remaining;
      int                    sel;
      int                    span;
      int                    dx;
      int                    dy;
      int                    coord;
      int                    len;
      int                    advances;
      logic [COORD_BITS-1:0] xs;
      logic [COORD_BITS-1:0] ys;
      logic [COORD_BITS-1:0] xe;
      logic [COORD_BITS-1:0] ye;
      made = 0;
      remaining = 0;
      while (made < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 4) begin
            repeat ($urandom_range(1, 4)) begin
               send_advance();
               if (remaining > 0) begin
                  remaining--;
                  made++;
               end
            end
            continue;
         end
         xs = COORD_BITS'($urandom);
         ys = COORD_BITS'($urandom);
         if (sel < 12) begin
            xs = $urandom_range(0, 1) ? {COORD_BITS{1'b1}} : '0;
            ys = $urandom_range(0, 1) ? {COORD_BITS{1'b1}} : '0;
         end
         sel = $urandom_range(0, 99);
         span = (sel < 85) ? 16 : 100;
         if (sel >= 95) begin
            xe = COORD_BITS'($urandom);
            ye = COORD_BITS'($urandom);
         end else begin
            dx = $urandom_range(0, 2 * span) - span;
            dy = $urandom_range(0, 2 * span) - span;
            coord = int'(xs) + dx;
            if (coord < 0 || coord > COORD_MAX) coord = int'(xs) - dx;
            xe = COORD_BITS'(coord);
            coord = int'(ys) + dy;
            if (coord < 0 || coord > COORD_MAX) coord = int'(ys) - dy;
            ye = COORD_BITS'(coord);
         end
         dx = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
         dy = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
         len = (dx > dy) ? dx : dy;
         send_item(KIND_BEGIN, xs, ys, xe, ye);
         made++;
         remaining = len;
         sel = $urandom_range(0, 99);
         if (sel < 75) begin
            advances = len;
         end else if (sel < 88) begin
            advances = $urandom_range(0, len);
         end else begin
            advances = len + $urandom_range(1, 3);
         end
         // Long random lines are always cut short.
         if (len > 100 && advances > 20) begin
            advances = $urandom_range(0, 20);
         end
         repeat (advances) begin
            send_advance();
            if (remaining > 0) begin
               remaining--;
               made++;
            end
         end
      end
   endtask

   // Main stimulus sequence and verdict.
   initial begin
      int pitch_list[6];
      int oct_dx[8];
      int oct_dy[8];
      req_valid <= 1'b0;
      req_kind <= KIND_BEGIN;
      req_x_start <= '0;
      req_y_start <= '0;
      req_x_end <= '0;
      req_y_end <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      reset <= 1'b1;
      stall_mode = STALL_NONE;
      hold_long = 1'b0;
      burst_left = 1;
      gap_max = 0;
      items_sent = 0;
      lines_begun = 0;
      pitch_settings = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: advance with no line, zero-length line, advance after the
      // last pixel, full-extent lines dropped by a new begin, every octant.
      send_advance();
      send_item(KIND_BEGIN, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
      send_advance();
      send_item(KIND_BEGIN, '0, '0, COORD_TOP, COORD_TOP);
      send_advance();
      send_advance();
      send_item(KIND_BEGIN, COORD_TOP, COORD_TOP, '0, '0);
      send_advance();
      oct_dx = '{3, 1, -3, -1, 3, 1, -3, -1};
      oct_dy = '{1, 3, 1, 3, -1, -3, -1, -3};
      for (int i = 0; i < 8; i++) begin
         send_item(KIND_BEGIN, COORD_BITS'(2000), COORD_BITS'(2000),
                   COORD_BITS'(2000 + oct_dx[i]), COORD_BITS'(2000 + oct_dy[i]));
         send_advance();
      end
      send_advance();
      send_advance();
      drain_results();

      // Random phases, each under its own pitch, stall pattern and gap size.
      pitch_list = '{1, 4096, 0, 8191, 0, 0};
      pitch_list[4] = $urandom_range(1, 4096);
      pitch_list[5] = $urandom_range(0, 8191);
      for (int phase = 0; phase < 6; phase++) begin
         write_pitch(pitch_list[phase]);
         stall_mode = stall_mode_type'(phase % 4);
         gap_max = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 6);
         if (phase == 2) begin
            hold_long <= 1'b1;
         end
         run_random(300);
         drain_results();
         hold_long <= 1'b0;
      end

      repeat (16) @(posedge clock);
      $display("Summary: %0d items in %0d lines over %0d row pitch settings.",
               items_sent, lines_begun, pitch_settings);
      $display("Included every octant, zero-length and full-range lines and a long result hold.");
      if (error_count == 0) begin
         $display("octant_line_rasterizer test passed");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("octant_line_rasterizer test failed");
      end
      $finish;
   end

endmodule
